// ----- rtl/grh_pkg.sv -----
// Package for the horizontal grid-line ray hit block.
// Shared widths, configuration codes, payload layout and the
// controller/datapath command and status types. No dependencies.
package grh_pkg;

	// map geometry
	localparam int MAP_COLS  = 64;
	localparam int MAP_ROWS  = 64;
	localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int COL_W     = $clog2(MAP_COLS);
	localparam int ROW_W     = $clog2(MAP_ROWS);

	// fixed point
	localparam int POS_W     = 22;
	localparam int FRAC      = 8;
	localparam int MAX_SHIFT = 8;
	localparam int IT_W      = 24;
	localparam int SHIFT_W   = 4;
	localparam int SIZE_W    = 7;
	localparam int CFG_W     = 7;

	// internal arithmetic widths
	localparam int YW      = 25;                 // y walker, signed
	localparam int DY_W    = 18;                 // y0 - py, signed
	localparam int PROD_W  = DY_W + IT_W;        // dy * inverse tangent
	localparam int XW      = 40;                 // x walker, signed
	localparam int XS_W    = IT_W + MAX_SHIFT + 1; // x step after negation

	// stream payload
	localparam int IN_FIELDS_W  = 2 * COL_W + 1 + 2 * POS_W + IT_W + 4;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * POS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CFG_TILE_W_SHIFT = 2'd0,
		CFG_TILE_H_SHIFT = 2'd1,
		CFG_MAP_COLS     = 2'd2,
		CFG_MAP_ROWS     = 2'd3
	} cfg_idx_t;

	// clamped register values
	typedef struct packed {
		logic [SHIFT_W-1:0] tws;
		logic [SHIFT_W-1:0] ths;
		logic [SIZE_W-1:0]  cols;
		logic [SIZE_W-1:0]  rows;
	} cfg_t;

	// input word, first field in the lowest bits
	typedef struct packed {
		logic                   heading_right;
		logic                   heading_left;
		logic                   heading_down;
		logic                   heading_up;
		logic signed [IT_W-1:0] inverse_tangent;
		logic [POS_W-1:0]       origin_y;
		logic [POS_W-1:0]       origin_x;
		logic                   cell_is_wall;
		logic [ROW_W-1:0]       cell_row;
		logic [COL_W-1:0]       cell_column;
	} in_word_t;

	typedef struct packed {
		logic clear;
		logic write;
		logic load;
		logic mul;
		logic init;
		logic step;
		logic capture;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic hit;
		logic miss;
	} dp_sts_t;

endpackage

// ----- rtl/grh_cfg.sv -----
// Configuration registers of the ray hit block, with range clamping.
// Depends on grh_pkg.
module grh_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  grh_pkg::cfg_idx_t     cfg_index,
	input  logic [grh_pkg::CFG_W-1:0] cfg_data,
	output grh_pkg::cfg_t         cfg
);
	import grh_pkg::*;

	logic [SHIFT_W-1:0] tws_q, ths_q;
	logic [SIZE_W-1:0]  cols_q, rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tws_q  <= SHIFT_W'(6);
			ths_q  <= SHIFT_W'(6);
			cols_q <= SIZE_W'(MAP_COLS);
			rows_q <= SIZE_W'(MAP_ROWS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TILE_W_SHIFT: tws_q  <= cfg_data[SHIFT_W-1:0];
				CFG_TILE_H_SHIFT: ths_q  <= cfg_data[SHIFT_W-1:0];
				CFG_MAP_COLS:     cols_q <= cfg_data[SIZE_W-1:0];
				CFG_MAP_ROWS:     rows_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.tws  = (tws_q > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : tws_q;
		cfg.ths  = (ths_q > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : ths_q;
		cfg.cols = (cols_q > SIZE_W'(MAP_COLS)) ? SIZE_W'(MAP_COLS) : cols_q;
		cfg.rows = (rows_q > SIZE_W'(MAP_ROWS)) ? SIZE_W'(MAP_ROWS) : rows_q;
	end

endmodule

// ----- rtl/grh_ctrl.sv -----
// Controller of the ray hit block: clear pass, word intake, cast sequencing
// and the output register handshake. Depends on grh_pkg.
module grh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  grh_pkg::dp_sts_t sts,
	output grh_pkg::dp_cmd_t cmd
);
	import grh_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_INIT,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   walk_end;

	assign walk_end = sts.hit || sts.miss;
	assign m_tvalid = out_valid_q;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				cmd.load  = s_tvalid && s_tuser;
				cmd.write = s_tvalid && !s_tuser;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_INIT: cmd.init = 1'b1;
			ST_WALK: begin
				cmd.step    = !walk_end;
				cmd.capture = walk_end;
			end
			ST_DONE: cmd.load_out = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: if (sts.clear_done) state_q <= ST_IDLE;
				ST_IDLE:  if (cmd.load) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_INIT;
				ST_INIT:  state_q <= ST_WALK;
				ST_WALK:  if (walk_end) state_q <= ST_DONE;
				ST_DONE:  if (cmd.load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/grh_dp.sv -----
// Datapath of the ray hit block: wall map memory with clear counter,
// first-crossing arithmetic, row walker with one map read per step, and
// result/output registers. Depends on grh_pkg.
module grh_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  grh_pkg::cfg_t             cfg,
	input  grh_pkg::in_word_t         in_w,
	input  grh_pkg::dp_cmd_t          cmd,
	output grh_pkg::dp_sts_t          sts,
	output logic                      hit_found,
	output logic [grh_pkg::POS_W-1:0] hit_x,
	output logic [grh_pkg::POS_W-1:0] hit_y
);
	import grh_pkg::*;

	// wall map, one bit per cell, row major
	logic              map_q [MAP_DEPTH];
	logic [MAP_AW-1:0] clr_q;
	logic [MAP_AW-1:0] waddr, raddr;
	logic              wr_ok;

	// cast operands
	logic [POS_W-1:0]       px_q, py_q;
	logic signed [IT_W-1:0] it_q;
	logic                   up_q, down_q, left_q, right_q;

	// arithmetic
	logic [4:0]               hsh, wsh;
	logic [YW-1:0]            tile_h;
	logic signed [YW-1:0]     py_ext, y0, y_lim, y_row;
	logic signed [DY_W-1:0]   dy;
	logic signed [XS_W-1:0]   xs_raw, xs_adj;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [XS_W-1:0]   xs_q;
	logic signed [XW-1:0]     x_q, x0, x_lim;
	logic signed [YW-1:0]     y_q;
	logic                     in_map, row_ok;
	logic [COL_W-1:0]         col;
	logic [ROW_W-1:0]         row;

	// walker stage
	logic             vld_s1, ok_s1, end_s1, rd_s1;
	logic [POS_W-1:0] x_s1, y_s1;

	// result
	logic             res_found_q, out_found_q;
	logic [POS_W-1:0] res_x_q, res_y_q, out_x_q, out_y_q;

	always_comb begin
		hsh    = 5'({1'b0, cfg.ths}) + 5'(FRAC);
		wsh    = 5'({1'b0, cfg.tws}) + 5'(FRAC);
		tile_h = YW'(1) << hsh;
		py_ext = signed'(YW'(py_q));
		y0     = signed'((py_ext & ~(tile_h - YW'(1))) + (down_q ? tile_h : YW'(0)));
		dy     = signed'(DY_W'(y0 - py_ext));
		xs_raw = XS_W'(it_q) <<< cfg.ths;
		if (left_q && xs_raw > 0)
			xs_adj = -xs_raw;
		else if (right_q && xs_raw < 0)
			xs_adj = -xs_raw;
		else
			xs_adj = xs_raw;
		x0 = signed'(XW'(px_q)) + signed'(XW'(prod_q >>> FRAC));
	end

	// map bounds and cell address of the current crossing
	always_comb begin
		x_lim  = signed'(XW'(cfg.cols) << wsh);
		y_lim  = signed'(YW'(cfg.rows) << hsh);
		in_map = (x_q >= 0) && (x_q < x_lim) && (y_q >= 0) && (y_q < y_lim);
		// facing up checks the cell above the line; above row 0 is outside
		row_ok = !(up_q && (y_q < signed'(YW'(1 << FRAC))));
		y_row  = up_q ? (y_q - signed'(YW'(1 << FRAC))) : y_q;
		col    = COL_W'(x_q >>> wsh);
		row    = ROW_W'(y_row >>> hsh);
		raddr  = MAP_AW'(MAP_AW'(row) * MAP_AW'(MAP_COLS)) + MAP_AW'(col);
		waddr  = MAP_AW'(MAP_AW'(in_w.cell_row) * MAP_AW'(MAP_COLS))
			+ MAP_AW'(in_w.cell_column);
		wr_ok  = ({1'b0, in_w.cell_column} < (COL_W+1)'(MAP_COLS))
			&& ({1'b0, in_w.cell_row} < (ROW_W+1)'(MAP_ROWS));
	end

	assign sts.clear_done = (clr_q == MAP_AW'(MAP_DEPTH - 1));
	assign sts.hit        = vld_s1 && ok_s1 && rd_s1;
	assign sts.miss       = vld_s1 && end_s1;

	always_ff @(posedge clk) begin
		if (cmd.clear)
			map_q[clr_q] <= 1'b0;
		else if (cmd.write && wr_ok)
			map_q[waddr] <= in_w.cell_is_wall;
	end

	always_ff @(posedge clk) begin
		rd_s1 <= map_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear)
				clr_q <= clr_q + MAP_AW'(1);
			vld_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q    <= in_w.origin_x;
			py_q    <= in_w.origin_y;
			it_q    <= in_w.inverse_tangent;
			up_q    <= in_w.heading_up;
			down_q  <= in_w.heading_down;
			left_q  <= in_w.heading_left;
			right_q <= in_w.heading_right;
		end
		if (cmd.mul) begin
			prod_q <= dy * it_q;
			y_q    <= y0;
			xs_q   <= xs_adj;
		end
		if (cmd.init)
			x_q <= x0;
		if (cmd.step) begin
			x_q    <= x_q + XW'(xs_q);
			y_q    <= up_q ? (y_q - signed'(tile_h)) : (y_q + signed'(tile_h));
			// inside the map both coordinates fit the position width
			x_s1   <= POS_W'(x_q);
			y_s1   <= POS_W'(y_q);
			ok_s1  <= in_map && row_ok;
			end_s1 <= !in_map;
		end
		if (cmd.capture) begin
			res_found_q <= sts.hit;
			res_x_q     <= sts.hit ? x_s1 : '0;
			res_y_q     <= sts.hit ? y_s1 : '0;
		end
		if (cmd.load_out) begin
			out_found_q <= res_found_q;
			out_x_q     <= res_x_q;
			out_y_q     <= res_y_q;
		end
	end

	assign hit_found = out_found_q;
	assign hit_x     = out_x_q;
	assign hit_y     = out_y_q;

endmodule

// ----- rtl/grid_ray_horizontal_hit_top.sv -----
// Top level of the horizontal grid-line ray hit block.
// Depends on grh_pkg, grh_cfg, grh_ctrl and grh_dp.
//
// Keeps a 64 x 64 one-bit wall map and answers ray casts against horizontal
// tile boundaries. After reset the map is cleared one cell per clock, so
// s_tready stays low until every cell is cleared; config writes are taken
// during that time. A cell write word (tuser = 0) gives no result and
// leaves the block ready for the next word. A cast word (tuser = 1) goes
// through a multiply state and an init state, then the walker makes one map
// read per tile row, the read registered, until it finds a wall or leaves
// the map. One result word per cast; the output register holds it while
// the next word is taken.
// Positions are unsigned with 8 fraction bits; no-hit results report 0.
module grid_ray_horizontal_hit_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cell_column, cell_row, cell_is_wall, origin_x, origin_y,
	// inverse_tangent, heading_up, heading_down, heading_left, heading_right
	input  logic [grh_pkg::IN_TDATA_W-1:0]   s_tdata,
	// action
	input  logic                             s_tuser,
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// hit_x, hit_y
	output logic [grh_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// hit_found
	output logic                             m_tuser,
	// config write port
	input  logic                             cfg_we,
	input  grh_pkg::cfg_idx_t                cfg_index,
	input  logic [grh_pkg::CFG_W-1:0]        cfg_data
);
	import grh_pkg::*;

	cfg_t             cfg;
	in_word_t         in_w;
	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [POS_W-1:0] hit_x, hit_y;

	// fields from the low bits; pad bits above are ignored
	assign in_w = in_word_t'(s_tdata[IN_FIELDS_W-1:0]);

	grh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencing: clear pass, intake, multiply, init, walk, hand-off
	grh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	grh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_w      (in_w),
		.cmd       (cmd),
		.sts       (sts),
		.hit_found (m_tuser),
		.hit_x     (hit_x),
		.hit_y     (hit_y)
	);

	// result word: hit_x low, hit_y above, zero pad to a byte boundary
	assign m_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), hit_y, hit_x};

endmodule

// ----- rtl/grh_check.sv -----
// Port-level checker for the ray hit block, bound to the top level.
// Depends on grh_pkg.
module grh_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [grh_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [grh_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser,
	input logic                            cfg_we,
	input grh_pkg::cfg_idx_t               cfg_index,
	input logic [grh_pkg::CFG_W-1:0]       cfg_data
);
	import grh_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed under stall");

	// a miss reports a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero coordinates");

	// map clear pass follows reset
	a_clear_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !s_tready)
		else $error("ready during map clear");

	// a cast occupies the block; a cell write does not
	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("ready right after cast word");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> s_tready)
		else $error("cell write stalled intake");

endmodule

bind grid_ray_horizontal_hit_top grh_check u_grh_check (.*);
